@@ rtl/ipv6_packet_fnv1a_hasher_macros.svh @@
// Assertion macros shared by the IPv6 packet FNV-1a hasher.
// They expect clk_i and rst_ni to be in scope where they are used.
`ifndef IPV6_PACKET_FNV1A_HASHER_MACROS_SVH
`define IPV6_PACKET_FNV1A_HASHER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPV6FNV_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ipv6fnv: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define IPV6FNV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ipv6fnv: next-cycle check failed");

`endif

@@ rtl/ipv6fnv_pkg.sv @@
// Types, constants and the FNV-1a mixing function of the IPv6 packet hasher.
// No dependencies; used by every module of the block.
package ipv6fnv_pkg;

  localparam logic [31:0] HASH_BASIS    = 32'h811c9dc5;
  localparam logic [31:0] HASH_PRIME    = 32'h01000193;
  localparam logic [16:0] POS_MAX       = 17'h1FFFF;
  localparam logic [16:0] PLEN_HI_POS   = 17'd4;
  localparam logic [16:0] PLEN_LO_POS   = 17'd5;
  localparam logic [16:0] NH_POS        = 17'd6;
  localparam logic [16:0] ADDR_START    = 17'd8;
  localparam logic [16:0] HEADER_BYTES  = 17'd40;
  localparam logic [7:0]  NH_HOP_BY_HOP = 8'd0;

  typedef struct packed {
    logic [31:0] packet_hash;
    logic        truncated;
  } result_t;

  function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * HASH_PRIME;
  endfunction

endpackage

@@ rtl/ipv6_packet_fnv1a_hasher.sv @@
// Channel   Handshake              Payload
// input     in_valid_i/in_stall_o  packet_byte_i, last_byte_i
// output    out_valid_o/out_stall_i packet_hash_o, truncated_o
//
// One packet byte is taken in every cycle unless the input stalls; the hash state
// is updated by at most one FNV-1a multiply per transfer, and results are registered.
// Reset (rst_ni, asynchronous) returns the hash state and the result buffer to empty.
// Input stalls only when the result register and its skid stage are both full.
// Top level of the IPv6 packet FNV-1a hasher; uses ipv6fnv_pkg, ipv6fnv_parser,
// ipv6fnv_outbuf and the assertion macros header.
`include "ipv6_packet_fnv1a_hasher_macros.svh"

module ipv6_packet_fnv1a_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  packet_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] packet_hash_o,
  output logic        truncated_o
);

  logic                 accept;
  logic                 full;
  ipv6fnv_pkg::result_t result;
  ipv6fnv_pkg::result_t out_data;

  assign accept     = in_valid_i && !full;
  assign in_stall_o = full;

  ipv6fnv_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .packet_byte_i (packet_byte_i),
    .last_byte_i   (last_byte_i),
    .result_o      (result)
  );

  ipv6fnv_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && last_byte_i),
    .push_data_i (result),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign packet_hash_o = out_data.packet_hash;
  assign truncated_o   = out_data.truncated;

  `IPV6FNV_ASSERT_SAME(a_skid_implies_out, in_stall_o, out_valid_o)
  `IPV6FNV_ASSERT_NEXT(a_last_gives_result, in_valid_i && !in_stall_o && last_byte_i, out_valid_o)
  `IPV6FNV_ASSERT_NEXT(a_skid_refills_out, out_valid_o && !out_stall_i && in_stall_o, out_valid_o)
  `IPV6FNV_ASSERT_SAME(a_hash_nonzero, out_valid_o, packet_hash_o != 32'd0)

endmodule

@@ rtl/ipv6fnv_parser.sv @@
// Header parser and FNV-1a hash state of the IPv6 packet hasher.
// Depends on ipv6fnv_pkg; gives the result of the byte being transferred.
module ipv6fnv_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            packet_byte_i,
  input  logic                  last_byte_i,
  output ipv6fnv_pkg::result_t  result_o
);

  logic [16:0] pos_q, pos_d, pos_next;
  logic [7:0]  nh_q, nh_d;
  logic [15:0] plen_q, plen_d;
  logic [31:0] hash_q, hash_d;
  logic [31:0] premix_q, premix_d;
  logic [11:0] skip_q, skip_d;
  logic [15:0] cons_q, cons_d;

  logic        hbh;
  logic        in_payload;
  logic        use_premix;
  logic [31:0] mix_src, mixed;
  logic [11:0] hbh_len;
  logic [31:0] final_hash;

  assign hbh      = (nh_q == ipv6fnv_pkg::NH_HOP_BY_HOP) && (plen_q >= 16'd2);
  assign hbh_len  = {1'b0, packet_byte_i, 3'b000} + 12'd8;
  assign pos_next = (pos_q == ipv6fnv_pkg::POS_MAX) ? pos_q : pos_q + 17'd1;
  assign in_payload = (pos_q >= ipv6fnv_pkg::HEADER_BYTES) && (cons_q < plen_q);
  assign use_premix = in_payload && (cons_q == 16'd1) && hbh;
  assign mix_src  = use_premix ? premix_q : hash_q;
  assign mixed    = ipv6fnv_pkg::fnv_mix(mix_src, packet_byte_i);

  always_comb begin
    nh_d     = nh_q;
    plen_d   = plen_q;
    hash_d   = hash_q;
    premix_d = premix_q;
    skip_d   = skip_q;
    cons_d   = cons_q;
    if (pos_q == ipv6fnv_pkg::PLEN_HI_POS) begin
      plen_d = {packet_byte_i, 8'd0};
    end else if (pos_q == ipv6fnv_pkg::PLEN_LO_POS) begin
      plen_d = {plen_q[15:8], packet_byte_i};
    end else if (pos_q == ipv6fnv_pkg::NH_POS) begin
      nh_d = packet_byte_i;
    end else if (pos_q inside {[ipv6fnv_pkg::ADDR_START:ipv6fnv_pkg::HEADER_BYTES - 17'd1]}) begin
      hash_d = mixed;
    end else if (in_payload) begin
      cons_d = cons_q + 16'd1;
      if (cons_q == 16'd0 && hbh) begin
        premix_d = mixed;
      end else if (use_premix) begin
        if ({4'd0, hbh_len} <= plen_q) begin
          skip_d = hbh_len - 12'd2;
        end else begin
          hash_d = mixed;
        end
      end else if (skip_q != 12'd0) begin
        skip_d = skip_q - 12'd1;
      end else begin
        hash_d = mixed;
      end
    end
    pos_d = pos_next;
  end

  // A held first payload byte is hashed as plain payload when the packet ends.
  always_comb begin
    if (cons_d == 16'd1 && hbh) begin
      final_hash = (cons_q == 16'd0) ? mixed : premix_q;
    end else begin
      final_hash = hash_d;
    end
  end

  assign result_o.packet_hash = (final_hash == 32'd0) ? 32'd1 : final_hash;
  assign result_o.truncated   = pos_next < (ipv6fnv_pkg::HEADER_BYTES + {1'b0, plen_d});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      nh_q     <= '0;
      plen_q   <= '0;
      hash_q   <= ipv6fnv_pkg::HASH_BASIS;
      premix_q <= '0;
      skip_q   <= '0;
      cons_q   <= '0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        pos_q    <= '0;
        nh_q     <= '0;
        plen_q   <= '0;
        hash_q   <= ipv6fnv_pkg::HASH_BASIS;
        premix_q <= '0;
        skip_q   <= '0;
        cons_q   <= '0;
      end else begin
        pos_q    <= pos_d;
        nh_q     <= nh_d;
        plen_q   <= plen_d;
        hash_q   <= hash_d;
        premix_q <= premix_d;
        skip_q   <= skip_d;
        cons_q   <= cons_d;
      end
    end
  end

endmodule

@@ rtl/ipv6fnv_outbuf.sv @@
// Result register with a skid stage for the IPv6 packet hasher.
// Depends on ipv6fnv_pkg for the result type.
module ipv6fnv_outbuf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ipv6fnv_pkg::result_t  push_data_i,
  output logic                  full_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ipv6fnv_pkg::result_t  out_data_o
);

  logic                 out_valid_q, skid_valid_q;
  ipv6fnv_pkg::result_t out_q, skid_q;
  logic                 pop;

  assign pop = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_q <= push_data_i;
      end else begin
        skid_q <= push_data_i;
      end
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ sim/tb_ipv6_packet_fnv1a_hasher.sv @@
// Self-checking testbench for the IPv6 packet FNV-1a hasher: packets are streamed byte by
// byte under random idling on both channels and every hash is checked against a local model.
// Depends on ipv6fnv_pkg and the ipv6_packet_fnv1a_hasher RTL.
`timescale 1ns / 100ps

module tb_ipv6_packet_fnv1a_hasher;

  localparam int TAIL_ITEMS        = 400;
  localparam int HOLD_OFF_CYCLES   = 400;
  localparam int WATCHDOG_LIMIT    = 4000;
  localparam int DRAIN_CYCLES      = 20;
  localparam int LONG_PACKET_BYTES = 240;
  localparam int ZERO_PREFIX_BYTES = 28;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } wire_byte_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [7:0]  packet_byte_i = 8'h00;
  logic        last_byte_i   = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [31:0] packet_hash_o;
  logic        truncated_o;

  wire_byte_t            byte_stream[$];
  ipv6fnv_pkg::result_t  pending_hashes[$];
  wire_byte_t            next_byte;

  logic [16:0] cur_pos;
  logic [7:0]  cur_nh;
  logic [15:0] cur_plen;
  logic [31:0] cur_hash;
  logic [7:0]  cur_held;
  logic [11:0] cur_skip;
  logic [15:0] cur_taken;

  logic [8:0]  tail_by_key [0:65535];

  int send_gap      = 0;
  int stall_left    = 0;
  int hold_off_left = 0;
  bit hold_off_done = 1'b0;
  int results_seen  = 0;
  int error_count   = 0;
  int quiet_cycles  = 0;
  int random_items  = 0;

  ipv6_packet_fnv1a_hasher uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .packet_byte_i (packet_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .packet_hash_o (packet_hash_o),
    .truncated_o   (truncated_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] folded;
    folded = h ^ {24'h000000, b};
    return folded * ipv6fnv_pkg::HASH_PRIME;
  endfunction

  function automatic bit in_tail();
    return byte_stream.size() < TAIL_ITEMS;
  endfunction

  function automatic bit hop_by_hop_first();
    return cur_nh == ipv6fnv_pkg::NH_HOP_BY_HOP && cur_plen >= 16'd2;
  endfunction

  task automatic clear_packet_state();
    cur_pos   = '0;
    cur_nh    = '0;
    cur_plen  = '0;
    cur_hash  = ipv6fnv_pkg::HASH_BASIS;
    cur_held  = '0;
    cur_skip  = '0;
    cur_taken = '0;
  endtask

  task automatic take_payload_byte(input logic [7:0] b);
    int idx;
    int hbh_len;
    if (cur_taken >= cur_plen) return;
    idx = int'(cur_taken);
    cur_taken = cur_taken + 16'd1;
    if (idx == 0 && hop_by_hop_first()) begin
      cur_held = b;
    end else if (idx == 1 && hop_by_hop_first()) begin
      hbh_len = (int'(b) + 1) * 8;
      if (hbh_len <= int'(cur_plen)) begin
        cur_skip = 12'(hbh_len - 2);
      end else begin
        cur_hash = fnv_step(cur_hash, cur_held);
        cur_hash = fnv_step(cur_hash, b);
      end
    end else if (cur_skip != 12'd0) begin
      cur_skip = cur_skip - 12'd1;
    end else begin
      cur_hash = fnv_step(cur_hash, b);
    end
  endtask

  task automatic hash_packet_byte(input logic [7:0] b, input logic last);
    ipv6fnv_pkg::result_t res;
    if (cur_pos == ipv6fnv_pkg::PLEN_HI_POS) cur_plen = {b, 8'h00};
    else if (cur_pos == ipv6fnv_pkg::PLEN_LO_POS) cur_plen[7:0] = b;
    else if (cur_pos == ipv6fnv_pkg::NH_POS) cur_nh = b;
    else if (cur_pos >= ipv6fnv_pkg::ADDR_START && cur_pos < ipv6fnv_pkg::HEADER_BYTES)
      cur_hash = fnv_step(cur_hash, b);
    else if (cur_pos >= ipv6fnv_pkg::HEADER_BYTES) take_payload_byte(b);
    if (cur_pos != ipv6fnv_pkg::POS_MAX) cur_pos = cur_pos + 17'd1;
    if (last) begin
      if (cur_taken == 16'd1 && hop_by_hop_first()) cur_hash = fnv_step(cur_hash, cur_held);
      res.truncated   = {15'd0, cur_pos} <
                        {15'd0, ipv6fnv_pkg::HEADER_BYTES} + {16'd0, cur_plen};
      res.packet_hash = (cur_hash == 32'd0) ? 32'd1 : cur_hash;
      pending_hashes.push_back(res);
      clear_packet_state();
    end
  endtask

  task automatic check_result(input logic [31:0] hash, input logic trunc);
    ipv6fnv_pkg::result_t want;
    results_seen++;
    if (pending_hashes.size() == 0) begin
      if (error_count < 10) $display("unexpected result: hash %h truncated %b", hash, trunc);
      error_count++;
    end else begin
      want = pending_hashes.pop_front();
      if (want.packet_hash !== hash) begin
        if (error_count < 10)
          $display("hash mismatch: expected %h, got %h", want.packet_hash, hash);
        error_count++;
      end
      if (want.truncated !== trunc) begin
        if (error_count < 10)
          $display("truncated mismatch: expected %b, got %b", want.truncated, trunc);
        error_count++;
      end
    end
  endtask

  task automatic push_item(input logic [7:0] data, input logic last);
    wire_byte_t item;
    item.data = data;
    item.last = last;
    byte_stream.push_back(item);
  endtask

  // A negative hbh_byte leaves the second payload byte random.
  task automatic queue_packet(input logic [15:0] plen, input logic [7:0] nh, input int total,
                              input int hbh_byte);
    logic [7:0] data;
    for (int i = 0; i < total; i++) begin
      data = 8'($urandom_range(0, 255));
      if (i == 4) data = plen[15:8];
      else if (i == 5) data = plen[7:0];
      else if (i == 6) data = nh;
      else if (i == 41 && hbh_byte >= 0) data = 8'(hbh_byte);
      push_item(data, i == total - 1);
    end
  endtask

  task automatic queue_random_packet();
    int shape;
    int plen;
    int nh;
    int total;
    int hbh;
    shape = $urandom_range(0, 99);
    hbh = -1;
    nh = $urandom_range(1, 255);
    if (shape < 20) begin
      plen = $urandom_range(0, 65535);
      nh = $urandom_range(0, 255);
      total = $urandom_range(1, 40);
    end else if (shape < 48) begin
      plen = $urandom_range(0, 48);
      total = 40 + plen + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
    end else if (shape < 76) begin
      nh = int'(ipv6fnv_pkg::NH_HOP_BY_HOP);
      plen = $urandom_range(8, 64);
      hbh = $urandom_range(0, plen / 8 - 1);
      total = 40 + plen + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
    end else if (shape < 84) begin
      nh = int'(ipv6fnv_pkg::NH_HOP_BY_HOP);
      plen = $urandom_range(2, 40);
      hbh = $urandom_range(plen / 8, 255);
      total = 40 + plen;
    end else if (shape < 90) begin
      nh = int'(ipv6fnv_pkg::NH_HOP_BY_HOP);
      plen = $urandom_range(2, 64);
      total = 41;
    end else if (shape < 95) begin
      nh = int'(ipv6fnv_pkg::NH_HOP_BY_HOP);
      plen = $urandom_range(16, 64);
      hbh = $urandom_range(1, plen / 8 - 1);
      total = $urandom_range(42, 39 + (hbh + 1) * 8);
    end else begin
      if ($urandom_range(0, 1) == 0) nh = int'(ipv6fnv_pkg::NH_HOP_BY_HOP);
      plen = $urandom_range(0, 80);
      total = $urandom_range(40, 42 + plen);
    end
    queue_packet(16'(plen), 8'(nh), total, hbh);
    random_items += total;
  endtask

  // Searches address bytes that drive the hash to zero: two bytes forward from a random
  // prefix are matched against two bytes worked backwards from zero.
  task automatic queue_zero_hash_packet();
    logic [7:0]  prefix [ZERO_PREFIX_BYTES];
    logic [31:0] inv;
    logic [31:0] s;
    logic [31:0] f;
    logic [31:0] k;
    logic [7:0]  lead_a;
    logic [7:0]  lead_b;
    logic [7:0]  tail_c;
    logic [7:0]  tail_d;
    bit          found;
    inv = ipv6fnv_pkg::HASH_PRIME;
    repeat (5) inv = inv * (32'd2 - ipv6fnv_pkg::HASH_PRIME * inv);
    found = 1'b0;
    while (!found) begin
      s = ipv6fnv_pkg::HASH_BASIS;
      for (int i = 0; i < ZERO_PREFIX_BYTES; i++) begin
        prefix[i] = 8'($urandom_range(0, 255));
        s = fnv_step(s, prefix[i]);
      end
      for (int i = 0; i < 65536; i++) tail_by_key[i] = '0;
      for (int d = 0; d < 256; d++) begin
        k = d * inv;
        tail_by_key[k[31:16]] = {1'b1, d[7:0]};
      end
      for (int a = 0; a < 65536 && !found; a++) begin
        f = fnv_step(fnv_step(s, a[15:8]), a[7:0]);
        if (tail_by_key[f[31:16]][8]) begin
          tail_d = tail_by_key[f[31:16]][7:0];
          k = {24'd0, tail_d} * inv;
          if (k[31:8] == f[31:8]) begin
            found  = 1'b1;
            lead_a = a[15:8];
            lead_b = a[7:0];
            tail_c = f[7:0] ^ k[7:0];
          end
        end
      end
    end
    for (int i = 0; i < 8; i++) begin
      if (i == 4 || i == 5) push_item(8'h00, 1'b0);
      else if (i == 6) push_item(8'h3B, 1'b0);
      else push_item(8'($urandom_range(0, 255)), 1'b0);
    end
    for (int i = 0; i < ZERO_PREFIX_BYTES; i++) push_item(prefix[i], 1'b0);
    push_item(lead_a, 1'b0);
    push_item(lead_b, 1'b0);
    push_item(tail_c, 1'b0);
    push_item(tail_d, 1'b1);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      packet_byte_i <= 8'h00;
      last_byte_i   <= 1'b0;
      send_gap      <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) hash_packet_byte(packet_byte_i, last_byte_i);
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (!in_tail() && $urandom_range(0, 19) == 0) begin
          send_gap   <= $urandom_range(0, 16);
          in_valid_i <= 1'b0;
        end else if (byte_stream.size() > 0) begin
          next_byte     = byte_stream.pop_front();
          in_valid_i    <= 1'b1;
          packet_byte_i <= next_byte.data;
          last_byte_i   <= next_byte.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // The long hold-off lets results pile up so that the input side is pushed into a stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i   <= 1'b0;
      stall_left    <= 0;
      hold_off_left <= 0;
      hold_off_done <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_result(packet_hash_o, truncated_o);
      if (hold_off_left > 0) begin
        hold_off_left <= hold_off_left - 1;
        out_stall_i   <= 1'b1;
      end else if (!hold_off_done && !in_tail() && results_seen >= 8) begin
        hold_off_done <= 1'b1;
        hold_off_left <= HOLD_OFF_CYCLES - 1;
        out_stall_i   <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left  <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (!in_tail() && $urandom_range(0, 11) == 0) begin
        stall_left  <= $urandom_range(0, 16);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("ipv6_packet_fnv1a_hasher test failed");
      $finish;
    end
  end

  initial begin
    clear_packet_state();
    push_item(8'hFF, 1'b1);
    push_item(8'h00, 1'b1);
    queue_packet(16'hFF00, 8'h00, 5, -1);
    queue_packet(16'h0000, 8'hFF, 7, -1);
    queue_packet(16'h0001, 8'h00, 10, -1);
    while (random_items < 775) queue_random_packet();
    queue_zero_hash_packet();
    queue_packet(16'hFFFF, ipv6fnv_pkg::NH_HOP_BY_HOP, LONG_PACKET_BYTES, 255);
    while (random_items < 1200) queue_random_packet();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(negedge clk_i);
    while (byte_stream.size() != 0 || in_valid_i || pending_hashes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0)
      $display("ipv6_packet_fnv1a_hasher test passed");
    else
      $display("ipv6_packet_fnv1a_hasher test failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ipv6fnv_pkg.sv
rtl/ipv6fnv_parser.sv
rtl/ipv6fnv_outbuf.sv
rtl/ipv6_packet_fnv1a_hasher.sv
sim/tb_ipv6_packet_fnv1a_hasher.sv
